@@ rtl/eawr_pkg.sv @@
// ----------------------------------------------------------------------------
// Ellipse arc row widths: shared package
// Widths, the walk operation codes and the structs passed between the
// sequencer, the walk unit and the row table.
// ----------------------------------------------------------------------------
`default_nettype none

package eawr_pkg;

    // Fixed field widths of the stream payloads.
    localparam int FIELD_W = 6;
    localparam int TDATA_W = 16;

    // Default largest radius and therefore default row table depth minus one.
    localparam int DEFAULT_MAX_RADIUS = 63;

    // Walk coordinates are small signed values; the error terms are wide.
    localparam int COORD_W = 8;
    localparam int TERM_W  = 24;

    // Squares of a radius, twice a square, and the product of that by a radius.
    localparam int SQ_W    = 2 * FIELD_W;
    localparam int MUL_A_W = SQ_W + 1;
    localparam int PROD_W  = MUL_A_W + FIELD_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TERM_W-1:0]  term_t;

    // One operation of the walk unit per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_AA,
        OP_MUL_BB,
        OP_R1_INIT,
        OP_R1_STEPX,
        OP_R1_A,
        OP_R1_B,
        OP_R2_INIT,
        OP_R2_STEPY,
        OP_R2_A,
        OP_R2_B,
        OP_GAP_DEC,
        OP_GAP_INC
    } walk_op_t;

    // A row write before mirroring, range check and clamping.
    typedef struct packed {
        logic   en;
        coord_t y;
        coord_t x;
    } put_t;

    // What the sequencer needs to see of the walk unit.
    typedef struct packed {
        logic   r1_go;
        logic   r2_go;
        logic   gap_go;
        coord_t walk_y;
        coord_t mid;
    } walk_stat_t;

endpackage

`default_nettype wire

@@ rtl/eawr_row_table.sv @@
// ----------------------------------------------------------------------------
// Ellipse arc row widths: row table
// One half-width per row, with a written mask that is cleared per request.
// ----------------------------------------------------------------------------
`default_nettype none

module eawr_row_table #(
    parameter int MAX_RADIUS = eawr_pkg::DEFAULT_MAX_RADIUS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 clear,
    input  wire eawr_pkg::put_t                       put,
    input  wire logic [eawr_pkg::FIELD_W-1:0]         limit,
    input  wire logic                                 rd_en,
    input  wire logic [$clog2(MAX_RADIUS + 1)-1:0]    rd_addr,
    output logic      [eawr_pkg::FIELD_W-1:0]         rd_data
);

    localparam int DEPTH = MAX_RADIUS + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam eawr_pkg::coord_t X_MAX = eawr_pkg::COORD_W'(MAX_RADIUS);

    logic [eawr_pkg::FIELD_W-1:0] row_mem_reg [DEPTH];
    logic [DEPTH-1:0]             valid_reg;
    logic [DEPTH-1:0]             valid_next;
    logic [eawr_pkg::FIELD_W-1:0] rd_data_reg;
    logic                         rd_valid_reg;

    logic [eawr_pkg::COORD_W-1:0] y_abs;
    logic                         we;
    logic [IDX_W-1:0]             wr_addr;
    logic [eawr_pkg::FIELD_W-1:0] wr_data;

    // Negative rows mirror to their positive row; rows beyond the limit drop.
    always_comb
    begin
        y_abs   = put.y[eawr_pkg::COORD_W-1] ? eawr_pkg::COORD_W'(-put.y)
                                             : eawr_pkg::COORD_W'(put.y);
        we      = put.en && (y_abs <= {{(eawr_pkg::COORD_W - eawr_pkg::FIELD_W){1'b0}}, limit});
        wr_addr = y_abs[IDX_W-1:0];
        if (put.x[eawr_pkg::COORD_W-1])
        begin
            wr_data = '0;
        end
        else if (put.x > X_MAX)
        begin
            wr_data = eawr_pkg::FIELD_W'(MAX_RADIUS);
        end
        else
        begin
            wr_data = put.x[eawr_pkg::FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem_reg[rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (we)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A row not written during this request reads as zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/eawr_walk_unit.sv @@
// ----------------------------------------------------------------------------
// Ellipse arc row widths: walk unit
// Shared multiplier and term adders of the midpoint walk, one operation
// per cycle as chosen by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module eawr_walk_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire eawr_pkg::walk_op_t           op,
    input  wire logic [eawr_pkg::FIELD_W-1:0] rx,
    input  wire logic [eawr_pkg::FIELD_W-1:0] ry,
    output eawr_pkg::walk_stat_t              stat,
    output eawr_pkg::put_t                    put
);

    localparam int TW = eawr_pkg::TERM_W;

    logic [eawr_pkg::SQ_W-1:0] aa_reg, aa_next;
    logic [eawr_pkg::SQ_W-1:0] bb_reg, bb_next;
    eawr_pkg::coord_t          walk_x_reg, walk_x_next;
    eawr_pkg::coord_t          walk_y_reg, walk_y_next;
    eawr_pkg::coord_t          mid_reg, mid_next;
    eawr_pkg::term_t           err_reg, err_next;
    eawr_pkg::term_t           step_x_reg, step_x_next;
    eawr_pkg::term_t           step_y_reg, step_y_next;
    eawr_pkg::term_t           stop_x_reg, stop_x_next;
    eawr_pkg::term_t           stop_y_reg, stop_y_next;

    logic [eawr_pkg::MUL_A_W-1:0] mul_a;
    logic [eawr_pkg::FIELD_W-1:0] mul_b;
    logic [eawr_pkg::PROD_W-1:0]  prod;
    eawr_pkg::term_t              prod_t;
    eawr_pkg::term_t              aa_t, bb_t, a2_t, b2_t;
    logic signed [TW:0]           dec_x, dec_y;

    assign aa_t   = $signed(TW'(aa_reg));
    assign bb_t   = $signed(TW'(bb_reg));
    assign a2_t   = $signed(TW'({aa_reg, 1'b0}));
    assign b2_t   = $signed(TW'({bb_reg, 1'b0}));
    assign prod_t = $signed(TW'(prod));

    // Decision values 2*err + step for the two regions.
    assign dec_x = (TW + 1)'(err_reg) + (TW + 1)'(err_reg) + (TW + 1)'(step_x_reg);
    assign dec_y = (TW + 1)'(err_reg) + (TW + 1)'(err_reg) + (TW + 1)'(step_y_reg);

    // Shared multiplier operand selection.
    always_comb
    begin
        case (op)
            eawr_pkg::OP_MUL_AA:
            begin
                mul_a = eawr_pkg::MUL_A_W'(rx);
                mul_b = rx;
            end
            eawr_pkg::OP_MUL_BB:
            begin
                mul_a = eawr_pkg::MUL_A_W'(ry);
                mul_b = ry;
            end
            eawr_pkg::OP_R1_INIT:
            begin
                mul_a = {bb_reg, 1'b0};
                mul_b = rx;
            end
            default:
            begin
                mul_a = {aa_reg, 1'b0};
                mul_b = ry;
            end
        endcase
    end

    assign prod = eawr_pkg::PROD_W'(mul_a * mul_b);

    always_comb
    begin
        aa_next     = aa_reg;
        bb_next     = bb_reg;
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        mid_next    = mid_reg;
        err_next    = err_reg;
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;
        stop_x_next = stop_x_reg;
        stop_y_next = stop_y_reg;
        put.en      = 1'b0;
        put.y       = walk_y_reg;
        put.x       = walk_x_reg;
        unique case (op)
            eawr_pkg::OP_NONE:
            begin
            end
            eawr_pkg::OP_MUL_AA:
            begin
                aa_next = prod[eawr_pkg::SQ_W-1:0];
            end
            eawr_pkg::OP_MUL_BB:
            begin
                bb_next = prod[eawr_pkg::SQ_W-1:0];
            end
            eawr_pkg::OP_R1_INIT:
            begin
                stop_x_next = prod_t;
                walk_x_next = $signed(eawr_pkg::COORD_W'(rx));
                walk_y_next = '0;
                step_y_next = aa_t;
                err_next    = '0;
                stop_y_next = '0;
            end
            eawr_pkg::OP_R1_STEPX:
            begin
                step_x_next = bb_t - stop_x_reg;
            end
            eawr_pkg::OP_R1_A:
            begin
                put.en      = 1'b1;
                walk_y_next = walk_y_reg + 2'sd1;
                stop_y_next = stop_y_reg + a2_t;
                err_next    = err_reg + step_y_reg;
                step_y_next = step_y_reg + a2_t;
            end
            eawr_pkg::OP_R1_B:
            begin
                if (dec_x > 0)
                begin
                    walk_x_next = walk_x_reg - 2'sd1;
                    stop_x_next = stop_x_reg - b2_t;
                    err_next    = err_reg + step_x_reg;
                    step_x_next = step_x_reg + b2_t;
                end
            end
            eawr_pkg::OP_R2_INIT:
            begin
                stop_y_next = prod_t;
                mid_next    = walk_y_reg;
                walk_x_next = '0;
                walk_y_next = $signed(eawr_pkg::COORD_W'(ry));
                step_x_next = bb_t;
                err_next    = '0;
                stop_x_next = '0;
            end
            eawr_pkg::OP_R2_STEPY:
            begin
                step_y_next = aa_t - stop_y_reg;
            end
            eawr_pkg::OP_R2_A:
            begin
                put.en      = 1'b1;
                walk_x_next = walk_x_reg + 2'sd1;
                stop_x_next = stop_x_reg + b2_t;
                err_next    = err_reg + step_x_reg;
                step_x_next = step_x_reg + b2_t;
            end
            eawr_pkg::OP_R2_B:
            begin
                if (dec_y > 0)
                begin
                    put.en      = 1'b1;
                    put.y       = walk_y_reg - 2'sd1;
                    walk_y_next = walk_y_reg - 2'sd1;
                    stop_y_next = stop_y_reg - a2_t;
                    err_next    = err_reg + step_y_reg;
                    step_y_next = step_y_reg + a2_t;
                end
            end
            eawr_pkg::OP_GAP_DEC:
            begin
                walk_y_next = walk_y_reg - 2'sd1;
            end
            eawr_pkg::OP_GAP_INC:
            begin
                mid_next = mid_reg + 2'sd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aa_reg     <= '0;
            bb_reg     <= '0;
            walk_x_reg <= '0;
            walk_y_reg <= '0;
            mid_reg    <= '0;
            err_reg    <= '0;
            step_x_reg <= '0;
            step_y_reg <= '0;
            stop_x_reg <= '0;
            stop_y_reg <= '0;
        end
        else
        begin
            aa_reg     <= aa_next;
            bb_reg     <= bb_next;
            walk_x_reg <= walk_x_next;
            walk_y_reg <= walk_y_next;
            mid_reg    <= mid_next;
            err_reg    <= err_next;
            step_x_reg <= step_x_next;
            step_y_reg <= step_y_next;
            stop_x_reg <= stop_x_next;
            stop_y_reg <= stop_y_next;
        end
    end

    assign stat.r1_go  = (stop_x_reg >= stop_y_reg);
    assign stat.r2_go  = (stop_x_reg <= stop_y_reg);
    assign stat.gap_go = (walk_y_reg > mid_reg);
    assign stat.walk_y = walk_y_reg;
    assign stat.mid    = mid_reg;

endmodule

`default_nettype wire

@@ rtl/ellipse_arc_row_widths_core.sv @@
// ----------------------------------------------------------------------------
// Ellipse arc row widths core
// Midpoint ellipse walk into a row table, then one half-width per row.
// ----------------------------------------------------------------------------
// Each input request carries the horizontal and vertical radii of an ellipse
// and produces radius_y + 1 results, one per row from the centre outwards,
// each giving the distance from the centre to the arc on that row; the final
// result of a request has tlast set. Radii above MAX_RADIUS saturate. A zero
// horizontal radius gives all zero widths, and a zero vertical radius gives a
// single row holding the horizontal radius. The block handles one request at
// a time and holds s_tready low from acceptance until the last result has
// been taken. Internally a small sequencer drives one shared walk unit (a
// multiplier and the term adders) at one operation per cycle: the setup
// squares both radii and prepares the first region, each step of the first
// region is a row write and an x decision, then the second region is set
// up and each of its steps is a write and a y decision, the rows left
// between the regions are filled in pairs from their neighbours, and each
// emitted row is a table read and then the result, because every row
// passes through the single registered read port of the row table.
// The row table needs no clearing pass: a mask of written rows is cleared in
// the cycle a request is accepted, and unwritten rows read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_arc_row_widths_core #(
    parameter int MAX_RADIUS = eawr_pkg::DEFAULT_MAX_RADIUS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // s_tdata: radius_x [5:0], radius_y [11:6], zero [15:12]
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [eawr_pkg::TDATA_W-1:0] s_tdata,
    // m_tdata: row_index [5:0], half_width [11:6], zero [15:12]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [eawr_pkg::TDATA_W-1:0] m_tdata,
    output logic                              m_tlast
);

    localparam int FW    = eawr_pkg::FIELD_W;
    localparam int IDX_W = $clog2(MAX_RADIUS + 1);
    localparam logic [FW-1:0] R_MAX = FW'(MAX_RADIUS);

    typedef enum logic [15:0] {
        S_IDLE      = 16'b0000_0000_0000_0001,
        S_PUT0      = 16'b0000_0000_0000_0010,
        S_MUL_AA    = 16'b0000_0000_0000_0100,
        S_MUL_BB    = 16'b0000_0000_0000_1000,
        S_R1_INIT   = 16'b0000_0000_0001_0000,
        S_R1_STEPX  = 16'b0000_0000_0010_0000,
        S_R1_A      = 16'b0000_0000_0100_0000,
        S_R1_B      = 16'b0000_0000_1000_0000,
        S_R2_INIT   = 16'b0000_0001_0000_0000,
        S_R2_STEPY  = 16'b0000_0010_0000_0000,
        S_R2_A      = 16'b0000_0100_0000_0000,
        S_R2_B      = 16'b0000_1000_0000_0000,
        S_GAP_DEC   = 16'b0001_0000_0000_0000,
        S_GAP_LOW   = 16'b0010_0000_0000_0000,
        S_GAP_HIGH  = 16'b0100_0000_0000_0000,
        S_EMIT      = 16'b1000_0000_0000_0000
    } state_t;

    // The emit phase alternates between a table read and showing the result,
    // tracked by a single flag alongside S_EMIT.
    state_t              state_reg, state_next;
    logic                emit_show_reg, emit_show_next;
    logic [FW-1:0]       rx_reg, rx_next;
    logic [FW-1:0]       ry_reg, ry_next;
    logic [FW-1:0]       row_cnt_reg, row_cnt_next;

    logic [FW-1:0]       rx_in, ry_in;
    logic                in_accept;
    logic                out_accept;
    logic                last_row;

    eawr_pkg::walk_op_t   op;
    eawr_pkg::walk_stat_t stat;
    eawr_pkg::put_t       walk_put;
    eawr_pkg::put_t       tbl_put;
    eawr_pkg::coord_t     mid_below;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [FW-1:0]        rd_data;

    // Saturate the incoming radii to the table size.
    assign rx_in = (s_tdata[FW-1:0] > R_MAX) ? R_MAX : s_tdata[FW-1:0];
    assign ry_in = (s_tdata[2*FW-1:FW] > R_MAX) ? R_MAX : s_tdata[2*FW-1:FW];

    assign s_tready   = (state_reg == S_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign m_tvalid   = (state_reg == S_EMIT) && emit_show_reg;
    assign out_accept = m_tvalid && m_tready;
    assign last_row   = (row_cnt_reg == ry_reg);
    assign mid_below  = stat.mid - 2'sd1;

    assign m_tdata = {{(eawr_pkg::TDATA_W - 2 * FW){1'b0}}, rd_data, row_cnt_reg};
    assign m_tlast = last_row;

    // Sequencer: picks the walk operation, the table accesses and the next
    // state. Loop tests are made at the head of each step, on settled terms.
    always_comb
    begin
        state_next     = state_reg;
        emit_show_next = emit_show_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        row_cnt_next   = row_cnt_reg;
        op             = eawr_pkg::OP_NONE;
        tbl_put        = walk_put;
        rd_en          = 1'b0;
        rd_addr        = row_cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    rx_next        = rx_in;
                    ry_next        = ry_in;
                    row_cnt_next   = '0;
                    emit_show_next = 1'b0;
                    if (rx_in == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (ry_in == '0)
                    begin
                        state_next = S_PUT0;
                    end
                    else
                    begin
                        state_next = S_MUL_AA;
                    end
                end
            end
            S_PUT0:
            begin
                tbl_put.en = 1'b1;
                tbl_put.y  = '0;
                tbl_put.x  = $signed(eawr_pkg::COORD_W'(rx_reg));
                state_next = S_EMIT;
            end
            S_MUL_AA:
            begin
                op         = eawr_pkg::OP_MUL_AA;
                state_next = S_MUL_BB;
            end
            S_MUL_BB:
            begin
                op         = eawr_pkg::OP_MUL_BB;
                state_next = S_R1_INIT;
            end
            S_R1_INIT:
            begin
                op         = eawr_pkg::OP_R1_INIT;
                state_next = S_R1_STEPX;
            end
            S_R1_STEPX:
            begin
                op         = eawr_pkg::OP_R1_STEPX;
                state_next = S_R1_A;
            end
            S_R1_A:
            begin
                if (stat.r1_go)
                begin
                    op         = eawr_pkg::OP_R1_A;
                    state_next = S_R1_B;
                end
                else
                begin
                    state_next = S_R2_INIT;
                end
            end
            S_R1_B:
            begin
                op         = eawr_pkg::OP_R1_B;
                state_next = S_R1_A;
            end
            S_R2_INIT:
            begin
                op         = eawr_pkg::OP_R2_INIT;
                state_next = S_R2_STEPY;
            end
            S_R2_STEPY:
            begin
                op         = eawr_pkg::OP_R2_STEPY;
                state_next = S_R2_A;
            end
            S_R2_A:
            begin
                if (stat.r2_go)
                begin
                    op         = eawr_pkg::OP_R2_A;
                    state_next = S_R2_B;
                end
                else
                begin
                    state_next = S_GAP_DEC;
                end
            end
            S_R2_B:
            begin
                op         = eawr_pkg::OP_R2_B;
                state_next = S_R2_A;
            end
            S_GAP_DEC:
            begin
                // Fetch the row above the one about to be filled.
                if (stat.gap_go)
                begin
                    op         = eawr_pkg::OP_GAP_DEC;
                    rd_en      = 1'b1;
                    rd_addr    = stat.walk_y[IDX_W-1:0];
                    state_next = S_GAP_LOW;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_GAP_LOW:
            begin
                tbl_put.en = 1'b1;
                tbl_put.y  = stat.walk_y;
                tbl_put.x  = $signed(eawr_pkg::COORD_W'(rd_data));
                if (stat.gap_go)
                begin
                    // Fetch the row below the lower edge of the gap.
                    rd_en      = 1'b1;
                    rd_addr    = mid_below[IDX_W-1:0];
                    state_next = S_GAP_HIGH;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_GAP_HIGH:
            begin
                op         = eawr_pkg::OP_GAP_INC;
                tbl_put.en = 1'b1;
                tbl_put.y  = stat.mid;
                tbl_put.x  = $signed(eawr_pkg::COORD_W'(rd_data));
                state_next = S_GAP_DEC;
            end
            S_EMIT:
            begin
                if (!emit_show_reg)
                begin
                    rd_en          = 1'b1;
                    emit_show_next = 1'b1;
                end
                else if (out_accept)
                begin
                    emit_show_next = 1'b0;
                    if (last_row)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_show_reg <= 1'b0;
            row_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_show_reg <= emit_show_next;
            row_cnt_reg   <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg <= rx_next;
        ry_reg <= ry_next;
    end

    eawr_walk_unit u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .rx    (rx_reg),
        .ry    (ry_reg),
        .stat  (stat),
        .put   (walk_put)
    );

    eawr_row_table #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (in_accept),
        .put     (tbl_put),
        .limit   (ry_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The block never offers a result while it is open for a new request.
    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("result offered while ready for a request");

    // After the last row is taken the block returns to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after the last row");

    // A fresh request cannot produce a result in the following cycle.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result shown before the table was read");

    // The emitted row never passes the vertical radius.
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (row_cnt_reg <= ry_reg))
        else $error("row index beyond vertical radius");

endmodule

`default_nettype wire
